>>> hdl/sicas_pkg.sv
// ----------------------------------------------------------------------------
// Sparse index check and scatter: shared definitions
// Widths, register indexes and the structs passed between the lanes, the
// check/state unit and the address pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sicas_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int COORD_BITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int EXT_BITS   = 16;
  localparam int IDX_BITS   = 31;
  localparam int ADDR_BITS  = 64;
  localparam int DIM_BITS   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Index value that means no entry has failed a check.
  localparam logic [IDX_BITS-1:0] NONE_INDEX = {IDX_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT = 3'd0,
    CFG_EXTENT_0  = 3'd1,
    CFG_EXTENT_1  = 3'd2,
    CFG_EXTENT_2  = 3'd3,
    CFG_EXTENT_3  = 3'd4,
    CFG_BROADCAST = 3'd5,
    CFG_SCALAR    = 3'd6
  } sicas_cfg_idx_t;

  // What one lane finds for its coordinate.
  typedef struct packed {
    logic oob;
    logic eq;
    logic lt;
  } sicas_lane_res_t;

  // Check results and payload that travel with an entry down the pipeline.
  typedef struct packed {
    logic                  oob;
    logic                  dec;
    logic                  rep;
    logic [IDX_BITS-1:0]   bad_bounds;
    logic [IDX_BITS-1:0]   bad_order;
    logic [IDX_BITS-1:0]   bad_repeat;
    logic [VALUE_BITS-1:0] data;
  } sicas_side_t;

endpackage

`default_nettype wire

>>> hdl/sicas_if.sv
// ----------------------------------------------------------------------------
// Sparse index check and scatter: channel interfaces
// Valid/ready channels for the sparse entry requests and the scatter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sicas_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    first_entry;
  logic signed [sicas_pkg::COORD_BITS-1:0] coord_0;
  logic signed [sicas_pkg::COORD_BITS-1:0] coord_1;
  logic signed [sicas_pkg::COORD_BITS-1:0] coord_2;
  logic signed [sicas_pkg::COORD_BITS-1:0] coord_3;
  logic [sicas_pkg::VALUE_BITS-1:0]        entry_value;

  modport source (output valid, first_entry, coord_0, coord_1, coord_2, coord_3,
                  entry_value, input ready);
  modport sink (input valid, first_entry, coord_0, coord_1, coord_2, coord_3,
                entry_value, output ready);
endinterface

interface sicas_out_if;
  logic                             valid;
  logic                             ready;
  logic                             write_enable;
  logic [sicas_pkg::ADDR_BITS-1:0]  dense_address;
  logic [sicas_pkg::VALUE_BITS-1:0] write_data;
  logic                             out_of_bounds;
  logic                             not_increasing;
  logic                             repeated;
  logic [sicas_pkg::IDX_BITS-1:0]   first_bad_bounds;
  logic [sicas_pkg::IDX_BITS-1:0]   first_bad_order;
  logic [sicas_pkg::IDX_BITS-1:0]   first_bad_repeat;

  modport source (output valid, write_enable, dense_address, write_data, out_of_bounds,
                  not_increasing, repeated, first_bad_bounds, first_bad_order,
                  first_bad_repeat, input ready);
  modport sink (input valid, write_enable, dense_address, write_data, out_of_bounds,
                not_increasing, repeated, first_bad_bounds, first_bad_order,
                first_bad_repeat, output ready);
endinterface

`default_nettype wire

>>> hdl/sicas_lane.sv
// ----------------------------------------------------------------------------
// Sparse index check and scatter: coordinate lane
// Bounds check of one coordinate and its signed compare with the previous entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sicas_lane (
  input  logic [sicas_pkg::COORD_BITS-1:0] coord,
  input  logic [sicas_pkg::COORD_BITS-1:0] prev,
  input  logic [sicas_pkg::EXT_BITS-1:0]   extent,
  output sicas_pkg::sicas_lane_res_t       res
);
  import sicas_pkg::*;

  always_comb begin
    // A negative coordinate or one at or past the extent is out of bounds.
    res.oob = coord[COORD_BITS-1] ||
              (coord >= {{(COORD_BITS-EXT_BITS){1'b0}}, extent});
    res.eq  = (coord == prev);
    res.lt  = ($signed(coord) < $signed(prev));
  end

endmodule

`default_nettype wire

>>> hdl/sicas_check.sv
// ----------------------------------------------------------------------------
// Sparse index check and scatter: check merge and set state
// Combines the lane results, keeps the entry counter, the first failure
// indexes and the previous coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module sicas_check (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    accept,
  input  logic                                    first_entry,
  input  logic [sicas_pkg::MAX_DIMS-1:0]          used,
  input  logic [sicas_pkg::MAX_DIMS-1:0][sicas_pkg::COORD_BITS-1:0] coords,
  input  sicas_pkg::sicas_lane_res_t [sicas_pkg::MAX_DIMS-1:0]      lane_res,
  input  logic [sicas_pkg::VALUE_BITS-1:0]        data,
  output logic [sicas_pkg::MAX_DIMS-1:0][sicas_pkg::COORD_BITS-1:0] prev,
  output sicas_pkg::sicas_side_t                  side
);
  import sicas_pkg::*;

  logic [MAX_DIMS-1:0][COORD_BITS-1:0] prev_r;
  logic [IDX_BITS-1:0] cnt_r, cnt_nxt;
  logic [IDX_BITS-1:0] bnd_r, bnd_nxt;
  logic [IDX_BITS-1:0] ord_r, ord_nxt;
  logic [IDX_BITS-1:0] rep_r, rep_nxt;
  logic [IDX_BITS-1:0] idx;
  logic oob, dec, rep, differ;

  assign prev = prev_r;

  always_comb begin
    oob    = 1'b0;
    dec    = 1'b0;
    differ = 1'b0;
    rep    = !first_entry;
    for (int i = 0; i < MAX_DIMS; i++) begin
      if (used[i]) begin
        oob = oob | lane_res[i].oob;
        if (!first_entry && !lane_res[i].eq) begin
          rep = 1'b0;
          if (!differ && lane_res[i].lt) begin
            dec = 1'b1;
          end
          differ = 1'b1;
        end
      end
    end

    // A first entry restarts the count and the failure indexes.
    idx     = first_entry ? '0 : cnt_r;
    bnd_nxt = first_entry ? NONE_INDEX : bnd_r;
    ord_nxt = first_entry ? NONE_INDEX : ord_r;
    rep_nxt = first_entry ? NONE_INDEX : rep_r;
    if (oob && idx < bnd_nxt) begin
      bnd_nxt = idx;
    end
    if (dec && idx < ord_nxt) begin
      ord_nxt = idx;
    end
    if (rep && idx < rep_nxt) begin
      rep_nxt = idx;
    end
    cnt_nxt = (idx != NONE_INDEX) ? idx + 1'b1 : idx;

    side.oob        = oob;
    side.dec        = dec;
    side.rep        = rep;
    side.bad_bounds = bnd_nxt;
    side.bad_order  = ord_nxt;
    side.bad_repeat = rep_nxt;
    side.data       = oob ? '0 : data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      cnt_r  <= '0;
      bnd_r  <= NONE_INDEX;
      ord_r  <= NONE_INDEX;
      rep_r  <= NONE_INDEX;
    end else if (accept) begin
      prev_r <= coords;
      cnt_r  <= cnt_nxt;
      bnd_r  <= bnd_nxt;
      ord_r  <= ord_nxt;
      rep_r  <= rep_nxt;
    end
  end

  // A recorded failure always lies behind the running count.
  a_bnd_behind: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_r != NONE_INDEX |-> bnd_r < cnt_r) else $error("bounds index ahead of count");
  a_ord_behind: assert property (@(posedge clk) disable iff (!rst_n)
    ord_r != NONE_INDEX |-> ord_r < cnt_r) else $error("order index ahead of count");
  a_rep_behind: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r != NONE_INDEX |-> rep_r < cnt_r) else $error("repeat index ahead of count");
  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && first_entry |=> cnt_r == IDX_BITS'(1)) else $error("set did not restart");

endmodule

`default_nettype wire

>>> hdl/sicas_addr.sv
// ----------------------------------------------------------------------------
// Sparse index check and scatter: address pipeline
// Row-major address built in Horner form, at most one extent multiply per stage,
// with the check results carried alongside. The last stage is the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sicas_addr (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  enable,
  input  logic                                                  accept,
  input  logic [sicas_pkg::MAX_DIMS-1:0]                        used,
  input  logic [sicas_pkg::MAX_DIMS-1:0][sicas_pkg::EXT_BITS-1:0] extent,
  input  logic [sicas_pkg::MAX_DIMS-1:0][sicas_pkg::EXT_BITS-1:0] coords,
  input  sicas_pkg::sicas_side_t                                side,
  output logic                                                  out_valid,
  output sicas_pkg::sicas_side_t                                out_side,
  output logic [sicas_pkg::ADDR_BITS-1:0]                       out_addr
);
  import sicas_pkg::*;

  localparam int A2_BITS = 2 * EXT_BITS;
  localparam int A3_BITS = 3 * EXT_BITS;

  logic [3:0] v_r;
  sicas_side_t side1_r, side2_r, side3_r, side4_r;
  logic [MAX_DIMS-1:0][EXT_BITS-1:0] c1_r;
  logic [EXT_BITS-1:0] c2_2_r, c2_3_r, c3_3_r;
  logic [A2_BITS-1:0] acc2_r;
  logic [A3_BITS-1:0] acc3_r;
  logic [ADDR_BITS-1:0] acc4_r;
  logic [A2_BITS-1:0] acc2_nxt;
  logic [A3_BITS-1:0] acc3_nxt;
  logic [ADDR_BITS-1:0] acc4_nxt;

  always_comb begin
    acc2_nxt = used[1] ? c1_r[0] * extent[1] + A2_BITS'(c1_r[1])
                       : A2_BITS'(c1_r[0]);
    acc3_nxt = used[2] ? acc2_r * extent[2] + A3_BITS'(c2_2_r)
                       : A3_BITS'(acc2_r);
    acc4_nxt = used[3] ? acc3_r * extent[3] + ADDR_BITS'(c3_3_r)
                       : ADDR_BITS'(acc3_r);
    if (side3_r.oob) begin
      acc4_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (enable) begin
      v_r <= {v_r[2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      side1_r <= side;
      c1_r    <= coords;
      side2_r <= side1_r;
      acc2_r  <= acc2_nxt;
      c2_2_r  <= c1_r[2];
      c2_3_r  <= c1_r[3];
      side3_r <= side2_r;
      acc3_r  <= acc3_nxt;
      c3_3_r  <= c2_3_r;
      side4_r <= side3_r;
      acc4_r  <= acc4_nxt;
    end
  end

  assign out_valid = v_r[3];
  assign out_side  = side4_r;
  assign out_addr  = acc4_r;

endmodule

`default_nettype wire

>>> hdl/sparse_index_check_and_scatter.sv
// ----------------------------------------------------------------------------
// Sparse index check and scatter
// Turns one sparse entry per request into a dense write with index checks.
// ----------------------------------------------------------------------------
// The block takes one sparse entry per request and returns one result from the
// four-stage address pipeline (at most one extent multiply per stage); it
// sustains one request per cycle except under a common stall that holds the
// whole pipeline while a result waits at the output. Four lanes check
// the coordinates side by side and a merge stage forms the out-of-bounds,
// not-increasing and repeated flags and updates the first-failure indexes,
// all in the cycle of acceptance. Configuration is written through the plain
// write port and must only change while no request is in flight.
`default_nettype none

module sparse_index_check_and_scatter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sicas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sicas_pkg::CFG_DATA_W-1:0]   cfg_data,
  sicas_in_if.sink                           in_req,
  sicas_out_if.source                        out_req
);
  import sicas_pkg::*;

  // Configuration registers.
  logic [DIM_BITS-1:0]                 dim_count_r;
  logic [MAX_DIMS-1:0][EXT_BITS-1:0]   extent_r;
  logic                                bcast_r;
  logic [VALUE_BITS-1:0]               scalar_r;

  logic [DIM_BITS-1:0]                 n_used;
  logic [MAX_DIMS-1:0]                 used;
  logic                                enable;
  logic                                accept;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] coords;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] prev;
  logic [MAX_DIMS-1:0][EXT_BITS-1:0]   coords_lo;
  sicas_lane_res_t [MAX_DIMS-1:0]      lane_res;
  sicas_side_t                         side;
  sicas_side_t                         out_side;
  logic [ADDR_BITS-1:0]                out_addr;
  logic                                out_valid;
  logic [VALUE_BITS-1:0]               data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= DIM_BITS'(1);
      extent_r    <= {MAX_DIMS{EXT_BITS'(1)}};
      bcast_r     <= 1'b0;
      scalar_r    <= '0;
    end else if (cfg_we) begin
      case (sicas_cfg_idx_t'(cfg_index))
        CFG_DIM_COUNT: dim_count_r <= cfg_data[DIM_BITS-1:0];
        CFG_EXTENT_0:  extent_r[0] <= cfg_data[EXT_BITS-1:0];
        CFG_EXTENT_1:  extent_r[1] <= cfg_data[EXT_BITS-1:0];
        CFG_EXTENT_2:  extent_r[2] <= cfg_data[EXT_BITS-1:0];
        CFG_EXTENT_3:  extent_r[3] <= cfg_data[EXT_BITS-1:0];
        CFG_BROADCAST: bcast_r     <= cfg_data[0];
        CFG_SCALAR:    scalar_r    <= cfg_data[VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A dimension count of zero acts as one; above the lane count it saturates.
  always_comb begin
    n_used = dim_count_r;
    if (dim_count_r == '0) begin
      n_used = DIM_BITS'(1);
    end else if (dim_count_r > DIM_BITS'(MAX_DIMS)) begin
      n_used = DIM_BITS'(MAX_DIMS);
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      used[i] = (DIM_BITS'(i) < n_used);
    end
  end

  // The whole pipeline advances unless a finished result is waiting.
  assign enable       = !out_valid || out_req.ready;
  assign in_req.ready = enable;
  assign accept       = in_req.valid && enable;

  assign coords[0] = in_req.coord_0;
  assign coords[1] = in_req.coord_1;
  assign coords[2] = in_req.coord_2;
  assign coords[3] = in_req.coord_3;
  assign data      = bcast_r ? scalar_r : in_req.entry_value;

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lane
    sicas_lane u_lane (
      .coord  (coords[g]),
      .prev   (prev[g]),
      .extent (extent_r[g]),
      .res    (lane_res[g])
    );
    // In-bounds coordinates fit the extent width; others are never used.
    assign coords_lo[g] = coords[g][EXT_BITS-1:0];
  end

  sicas_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .first_entry (in_req.first_entry),
    .used        (used),
    .coords      (coords),
    .lane_res    (lane_res),
    .data        (data),
    .prev        (prev),
    .side        (side)
  );

  sicas_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable),
    .accept    (accept),
    .used      (used),
    .extent    (extent_r),
    .coords    (coords_lo),
    .side      (side),
    .out_valid (out_valid),
    .out_side  (out_side),
    .out_addr  (out_addr)
  );

  assign out_req.valid            = out_valid;
  assign out_req.write_enable     = !out_side.oob;
  assign out_req.dense_address    = out_addr;
  assign out_req.write_data       = out_side.data;
  assign out_req.out_of_bounds    = out_side.oob;
  assign out_req.not_increasing   = out_side.dec;
  assign out_req.repeated         = out_side.rep;
  assign out_req.first_bad_bounds = out_side.bad_bounds;
  assign out_req.first_bad_order  = out_side.bad_order;
  assign out_req.first_bad_repeat = out_side.bad_repeat;

  // A suppressed write carries neither address nor data.
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_side.oob |-> out_addr == '0 && out_side.data == '0)
    else $error("suppressed write carries payload");
  // A repeat has no differing coordinate, so it cannot also be decreasing.
  a_rep_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_side.rep && out_side.dec))
    else $error("repeated and not increasing together");
  // A request cannot be accepted by the block's own ready while stalled.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_req.ready |-> !accept)
    else $error("request taken while output stalled");

endmodule

`default_nettype wire
